>>> src/phbm_pkg.sv
package phbm_pkg;

    // Sample and configuration widths fixed by the interface.
    localparam int unsigned PIX_IDX_W  = 16;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned NUM_COLOUR = 3;
    localparam int unsigned THR_W      = 9;
    localparam int unsigned NCH_W      = 2;
    localparam int unsigned NHIST_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // Slot count after clamping; the clamped count never exceeds 15.
    localparam int unsigned HIST_CNT_W = 6;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_CHANNELS  = 2'd1,
        CFG_HISTORY   = 2'd2
    } t_cfg_reg;

    // Colour samples of one pixel; entry 0 is blue, 1 green, 2 red.
    typedef logic [NUM_COLOUR-1:0][SAMPLE_W-1:0] t_chan_vals;

    // Clamped settings handed to the compare unit.
    typedef struct packed {
        logic [THR_W-1:0]      thr;
        logic [NCH_W-1:0]      nch;
        logic [HIST_CNT_W-1:0] nh;
    } t_match_cfg;

endpackage

>>> src/phbm_ram.sv
module phbm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/phbm_match.sv
module phbm_match #(
    parameter int unsigned MAX_HISTORY = 8,
    parameter int unsigned CHANNELS    = 3
) (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic [MAX_HISTORY*CHANNELS*phbm_pkg::SAMPLE_W-1:0] i_word,
    input  phbm_pkg::t_chan_vals                          i_vals,
    input  phbm_pkg::t_match_cfg                          i_cfg,
    output logic [phbm_pkg::NUM_COLOUR-1:0]               o_fg
);

    logic [phbm_pkg::NUM_COLOUR-1:0] hit;
    logic [phbm_pkg::NUM_COLOUR-1:0] r_fg;

    // Each channel compares against every stored slot in parallel.
    for (genvar k = 0; k < phbm_pkg::NUM_COLOUR; k++) begin : g_chan
        if (k < CHANNELS) begin : g_used
            always_comb begin
                logic [phbm_pkg::SAMPLE_W-1:0] s;
                logic [phbm_pkg::SAMPLE_W-1:0] d;
                hit[k] = 1'b0;
                for (int n = 0; n < MAX_HISTORY; n++) begin
                    s = i_word[(n*CHANNELS + k)*phbm_pkg::SAMPLE_W +: phbm_pkg::SAMPLE_W];
                    d = (i_vals[k] > s) ? (i_vals[k] - s) : (s - i_vals[k]);
                    if ((phbm_pkg::HIST_CNT_W'(n) < i_cfg.nh) &&
                        ({1'b0, d} < i_cfg.thr)) begin
                        hit[k] = 1'b1;
                    end
                end
            end
        end else begin : g_unused
            assign hit[k] = 1'b0;
        end
    end

    // A channel outside the active count always reads foreground.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < phbm_pkg::NUM_COLOUR; k++) begin
                r_fg[k] <= !(hit[k] && (phbm_pkg::NCH_W'(k) < i_cfg.nch));
            end
        end
    end

    assign o_fg = r_fg;

endmodule

>>> src/pixel_history_background_mask.sv
// Per-pixel background mask. Every pixel position owns one row of a single
// synchronous memory holding MAX_HISTORY samples of CHANNELS colour bytes.
// A learn beat (mode 0) writes the pixel into the current ring slot and,
// with frame_end set, advances the slot; it produces no output beat. A
// classify beat (mode 1) returns one output beat whose per-channel flag is 0
// for an active channel when any active slot lies within the threshold of the sample, else 1.
// Items are handled one at a time. Once an input beat is taken, the index is
// reduced modulo PIXELS in two halves of eight restoring steps, one as the beat
// is taken and one in ADDR while the memory row is read; READ then writes the
// merged row back (learn) or registers the compare (classify), and a classify
// beat then waits in PUT while the previous output beat is still held. After
// reset the block zeroes the memory one row per cycle before it takes input;
// configuration writes are accepted throughout.
module pixel_history_background_mask #(
    parameter int unsigned PIXELS      = 65536,
    parameter int unsigned MAX_HISTORY = 8,
    parameter int unsigned CHANNELS    = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [phbm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [phbm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_mode,
    input  logic [phbm_pkg::PIX_IDX_W-1:0]     i_pixel_index,
    input  logic [phbm_pkg::SAMPLE_W-1:0]      i_blue,
    input  logic [phbm_pkg::SAMPLE_W-1:0]      i_green,
    input  logic [phbm_pkg::SAMPLE_W-1:0]      i_red,
    input  logic                               i_frame_end,
    // Output channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [phbm_pkg::PIX_IDX_W-1:0]     o_pixel_out,
    output logic                               o_fg_blue,
    output logic                               o_fg_green,
    output logic                               o_fg_red
);

    localparam int unsigned ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned SLOT_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int unsigned WORD_W = MAX_HISTORY * CHANNELS * phbm_pkg::SAMPLE_W;
    localparam int unsigned IDX_W  = phbm_pkg::PIX_IDX_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_ADDR  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_PUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Eight restoring steps of the reduction modulo PIXELS.
    function automatic logic [IDX_W-1:0] f_reduce8(input logic [IDX_W-1:0] a,
                                                  input int unsigned base);
        logic [IDX_W-1:0] r;
        logic [39:0]      lim;
        r = a;
        for (int j = 7; j >= 0; j--) begin
            lim = 40'(PIXELS) << (j + base);
            if ({{(40-IDX_W){1'b0}}, r} >= lim) begin
                r = r - lim[IDX_W-1:0];
            end
        end
        return r;
    endfunction

    // Configuration registers
    logic [phbm_pkg::THR_W-1:0]   r_thr;
    logic [phbm_pkg::NCH_W-1:0]   r_nch;
    logic [phbm_pkg::NHIST_W-1:0] r_nhist;

    // Item registers
    logic                 r_mode;
    logic                 r_fend;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_rem;
    logic [ADDR_W-1:0]    r_addr;
    phbm_pkg::t_chan_vals r_vals;

    logic [SLOT_W-1:0]    r_wslot;
    logic [ADDR_W-1:0]    r_clr_addr;

    // Output register
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_pix_out;
    logic [phbm_pkg::NUM_COLOUR-1:0] r_fg_out;

    logic                          in_acc;
    logic [IDX_W-1:0]              rem_lo;
    logic [phbm_pkg::NCH_W-1:0]    eff_nch;
    logic [phbm_pkg::HIST_CNT_W-1:0] eff_nh;
    logic [phbm_pkg::HIST_CNT_W-1:0] slot_ext;
    logic [SLOT_W-1:0]             cur_slot;
    logic [phbm_pkg::HIST_CNT_W-1:0] slot_inc;
    phbm_pkg::t_match_cfg          match_cfg;
    logic [phbm_pkg::NUM_COLOUR-1:0] fg;
    logic                          out_load;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [WORD_W-1:0] ram_rd_data;
    logic [WORD_W-1:0] merged;

    assign in_acc = i_valid && o_ready;
    assign rem_lo = f_reduce8(r_rem, 0);

    // Clamp the channel and slot counts to what the store holds; a zero slot count becomes one.
    always_comb begin
        eff_nch = (r_nch > phbm_pkg::NCH_W'(CHANNELS)) ? phbm_pkg::NCH_W'(CHANNELS) : r_nch;
        eff_nh  = phbm_pkg::HIST_CNT_W'(r_nhist);
        if (eff_nh == '0) begin
            eff_nh = phbm_pkg::HIST_CNT_W'(1);
        end
        if (eff_nh > phbm_pkg::HIST_CNT_W'(MAX_HISTORY)) begin
            eff_nh = phbm_pkg::HIST_CNT_W'(MAX_HISTORY);
        end
    end

    // Slot that a learn beat writes and the slot after it.
    always_comb begin
        slot_ext = phbm_pkg::HIST_CNT_W'(r_wslot);
        cur_slot = (slot_ext < eff_nh) ? r_wslot : '0;
        slot_inc = phbm_pkg::HIST_CNT_W'(cur_slot) + phbm_pkg::HIST_CNT_W'(1);
    end

    assign match_cfg = '{thr: r_thr, nch: eff_nch, nh: eff_nh};

    // Learn: replace the active channels of the current slot, keep the rest.
    for (genvar n = 0; n < MAX_HISTORY; n++) begin : g_slot
        for (genvar k = 0; k < CHANNELS; k++) begin : g_ch
            localparam int unsigned LSB = (n*CHANNELS + k) * phbm_pkg::SAMPLE_W;
            assign merged[LSB +: phbm_pkg::SAMPLE_W] =
                ((cur_slot == SLOT_W'(n)) && (phbm_pkg::NCH_W'(k) < eff_nch)) ?
                r_vals[k] : ram_rd_data[LSB +: phbm_pkg::SAMPLE_W];
        end
    end

    // Memory port selection: clearing pass, read in ADDR, learn write-back in READ.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_addr;
        ram_wr_data = merged;
        if (r_state == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = '0;
        end else if ((r_state == ST_READ) && !r_mode) begin
            ram_wr_en   = 1'b1;
        end
        ram_rd_en = (r_state == ST_ADDR);
    end

    phbm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PIXELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ADDR_W'(rem_lo)),
        .o_rd_data (ram_rd_data)
    );

    phbm_match #(
        .MAX_HISTORY (MAX_HISTORY),
        .CHANNELS    (CHANNELS)
    ) u_match (
        .i_clk  (i_clk),
        .i_en   ((r_state == ST_READ) && r_mode),
        .i_word (ram_rd_data),
        .i_vals (r_vals),
        .i_cfg  (match_cfg),
        .o_fg   (fg)
    );

    assign out_load = (r_state == ST_PUT) && (!r_out_valid || i_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(PIXELS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = r_mode ? ST_PUT : ST_IDLE;
            end
            ST_PUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_wslot     <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= phbm_pkg::THR_W'(20);
            r_nch       <= phbm_pkg::NCH_W'(3);
            r_nhist     <= phbm_pkg::NHIST_W'(8);
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if ((r_state == ST_READ) && !r_mode && r_fend) begin
                r_wslot <= (slot_inc >= eff_nh) ? '0 : SLOT_W'(slot_inc);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    phbm_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data[phbm_pkg::THR_W-1:0];
                    phbm_pkg::CFG_CHANNELS:  r_nch   <= i_cfg_data[phbm_pkg::NCH_W-1:0];
                    phbm_pkg::CFG_HISTORY:   r_nhist <= i_cfg_data[phbm_pkg::NHIST_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_fend <= i_frame_end;
            r_idx  <= i_pixel_index;
            r_rem  <= f_reduce8(i_pixel_index, 8);
            r_vals <= {i_red, i_green, i_blue};
        end
        if (r_state == ST_ADDR) begin
            r_addr <= ADDR_W'(rem_lo);
        end
        if (out_load) begin
            r_pix_out <= r_idx;
            r_fg_out  <= fg;
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_pix_out;
    assign o_fg_blue   = r_fg_out[0];
    assign o_fg_green  = r_fg_out[1];
    assign o_fg_red    = r_fg_out[2];

endmodule

>>> src/phbm_checker.sv
module phbm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_mode,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [phbm_pkg::PIX_IDX_W-1:0] i_out_pixel,
    input logic                           i_out_fg_blue,
    input logic                           i_out_fg_green,
    input logic                           i_out_fg_red
);

    // Reset empties the output and holds off input.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("output valid or input ready straight after reset");

    // One item at a time: busy in the cycle after an input beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on consecutive cycles");

    // A learn beat never raises an output beat.
    a_learn_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_mode |=>
        !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("output beat raised by a learn item");

    // A new result only appears while an item is in flight.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel) &&
        $stable(i_out_fg_blue) && $stable(i_out_fg_green) && $stable(i_out_fg_red))
        else $error("stalled output beat changed");

endmodule

bind pixel_history_background_mask phbm_checker u_phbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_valid),
    .i_in_ready     (o_ready),
    .i_in_mode      (i_mode),
    .i_out_valid    (o_valid),
    .i_out_ready    (i_ready),
    .i_out_pixel    (o_pixel_out),
    .i_out_fg_blue  (o_fg_blue),
    .i_out_fg_green (o_fg_green),
    .i_out_fg_red   (o_fg_red)
);

>>> tb/tb_pixel_history_background_mask.sv
`timescale 1ns / 100ps

module tb_pixel_history_background_mask;
    import phbm_pkg::*;

    localparam int unsigned PIXELS        = 65536;
    localparam int unsigned MAX_HISTORY   = 8;
    localparam int unsigned CHANNELS      = 3;
    // The limit covers the clearing pass, and the rest is many times the slowest run.
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned PHASE_ITEMS   = 85;
    localparam int unsigned POOL_SIZE     = 10;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam bit          MODE_LEARN    = 1'b0;
    localparam bit          MODE_CLASSIFY = 1'b1;

    typedef struct packed {
        bit                 mode;
        bit [PIX_IDX_W-1:0] pixel_index;
        bit [SAMPLE_W-1:0]  blue;
        bit [SAMPLE_W-1:0]  green;
        bit [SAMPLE_W-1:0]  red;
        bit                 frame_end;
    } pixel_beat_t;

    typedef struct packed {
        bit [PIX_IDX_W-1:0] pixel_out;
        bit                 fg_blue;
        bit                 fg_green;
        bit                 fg_red;
    } mask_beat_t;

    // Background model of the block plus the queue of masks still to come out.
    class mask_scoreboard;
        bit [SAMPLE_W-1:0] samples [int unsigned];
        int unsigned       write_slot;
        bit [THR_W-1:0]    threshold;
        bit [NCH_W-1:0]    chan_count;
        bit [NHIST_W-1:0]  hist_count;
        mask_beat_t        awaited [$];
        int unsigned       mismatches;

        function new();
            write_slot = 0;
            threshold  = 20;
            chan_count = 3;
            hist_count = 8;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: threshold  = data[THR_W-1:0];
                CFG_CHANNELS:  chan_count = data[NCH_W-1:0];
                CFG_HISTORY:   hist_count = data[NHIST_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned store_key(int unsigned pix, int unsigned slot, int unsigned ch);
            return (pix * MAX_HISTORY + slot) * CHANNELS + ch;
        endfunction

        // Learn beats update the history; classify beats queue the mask they should give.
        function void note_beat(pixel_beat_t b);
            int unsigned       nch;
            int unsigned       nh;
            int unsigned       pix;
            int unsigned       slot;
            int                s;
            int                d;
            bit [SAMPLE_W-1:0] vals [3];
            bit [2:0]          fg;
            mask_beat_t        res;
            nch = (chan_count > CHANNELS) ? CHANNELS : chan_count;
            if (hist_count == 0) nh = 1;
            else if (hist_count > MAX_HISTORY) nh = MAX_HISTORY;
            else nh = hist_count;
            pix = b.pixel_index % PIXELS;
            vals[0] = b.blue;
            vals[1] = b.green;
            vals[2] = b.red;
            if (b.mode == MODE_LEARN) begin
                // A slot left beyond a shrunk ring falls back to slot 0.
                slot = (write_slot < nh) ? write_slot : 0;
                for (int k = 0; k < nch; k++) samples[store_key(pix, slot, k)] = vals[k];
                if (b.frame_end) write_slot = (slot + 1 >= nh) ? 0 : slot + 1;
            end else begin
                fg = 3'b111;
                for (int k = 0; k < nch; k++) begin
                    for (int n = 0; n < nh; n++) begin
                        // Slots never written still hold zero.
                        s = samples.exists(store_key(pix, n, k)) ?
                            int'(samples[store_key(pix, n, k)]) : 0;
                        d = (int'(vals[k]) > s) ? int'(vals[k]) - s : s - int'(vals[k]);
                        if (d < int'(threshold)) fg[k] = 1'b0;
                    end
                end
                res.pixel_out = b.pixel_index;
                res.fg_blue   = fg[0];
                res.fg_green  = fg[1];
                res.fg_red    = fg[2];
                awaited.push_back(res);
            end
        endfunction

        function void check_beat(mask_beat_t got);
            mask_beat_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected mask beat: pixel %0d fg b/g/r %b%b%b",
                             got.pixel_out, got.fg_blue, got.fg_green, got.fg_red);
                return;
            end
            want = awaited.pop_front();
            if (want != got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Mask mismatch: expected pixel %0d fg %b%b%b, got pixel %0d fg %b%b%b",
                             want.pixel_out, want.fg_blue, want.fg_green, want.fg_red,
                             got.pixel_out, got.fg_blue, got.fg_green, got.fg_red);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_mode;
    logic [PIX_IDX_W-1:0]  i_pixel_index;
    logic [SAMPLE_W-1:0]   i_blue;
    logic [SAMPLE_W-1:0]   i_green;
    logic [SAMPLE_W-1:0]   i_red;
    logic                  i_frame_end;
    logic                  o_valid;
    logic                  i_ready;
    logic [PIX_IDX_W-1:0]  o_pixel_out;
    logic                  o_fg_blue;
    logic                  o_fg_green;
    logic                  o_fg_red;

    mask_scoreboard    sb;
    int unsigned       burst_left;
    int unsigned       mask_beats;
    int unsigned       cycles;
    bit                held_off;
    bit [PIX_IDX_W-1:0] pool_pix  [POOL_SIZE];
    bit [SAMPLE_W-1:0]  pool_base [POOL_SIZE][3];

    pixel_history_background_mask #(
        .PIXELS      (PIXELS),
        .MAX_HISTORY (MAX_HISTORY),
        .CHANNELS    (CHANNELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_pixel_index (i_pixel_index),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_out   (o_pixel_out),
        .o_fg_blue     (o_fg_blue),
        .o_fg_green    (o_fg_green),
        .o_fg_red      (o_fg_red)
    );

    always #5 i_clk = ~i_clk;

    // A sample near a base colour, clamped to the byte range.
    function automatic bit [SAMPLE_W-1:0] near_value(bit [SAMPLE_W-1:0] base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[SAMPLE_W-1:0];
    endfunction

    // Offer one pixel beat, with bursts and gaps, and hold it until it is taken.
    task automatic send_beat(bit mode, bit [PIX_IDX_W-1:0] pix, bit [SAMPLE_W-1:0] b,
                             bit [SAMPLE_W-1:0] g, bit [SAMPLE_W-1:0] r, bit fe);
        pixel_beat_t beat;
        int unsigned gap;
        beat = '{mode, pix, b, g, r, fe};
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_mode        <= beat.mode;
        i_pixel_index <= beat.pixel_index;
        i_blue        <= beat.blue;
        i_green       <= beat.green;
        i_red         <= beat.red;
        i_frame_end   <= beat.frame_end;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_beat(beat);
    endtask

    task automatic write_reg(t_cfg_reg idx, bit [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Drain the block, let it settle, then load a new setting. Upper data bits are junk.
    task automatic apply_setting(bit [THR_W-1:0] thr, bit [NCH_W-1:0] nch, bit [NHIST_W-1:0] nh);
        bit [31:0] junk;
        junk = $urandom;
        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_CHANNELS, {junk[6:0], nch});
        write_reg(CFG_HISTORY, {junk[12:8], nh});
        i_cfg_we <= 1'b0;
    endtask

    // Mostly whole learn frames over a small pixel pool and classifies near the
    // learnt colours; the rest is random beats.
    task automatic run_phase(int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned p;
        sent = 0;
        pool_pix[0] = '0;
        pool_pix[1] = '1;
        for (p = 2; p < POOL_SIZE; p++) pool_pix[p] = PIX_IDX_W'($urandom_range(0, 65535));
        for (p = 0; p < POOL_SIZE; p++) begin
            for (int k = 0; k < 3; k++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) pool_base[p][k] = 8'd0;
                else if (pick == 1) pool_base[p][k] = 8'd255;
                else pool_base[p][k] = SAMPLE_W'($urandom_range(0, 255));
            end
        end
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                for (p = 0; p < POOL_SIZE; p++)
                    send_beat(MODE_LEARN, pool_pix[p], near_value(pool_base[p][0], 6),
                              near_value(pool_base[p][1], 6), near_value(pool_base[p][2], 6),
                              p == POOL_SIZE - 1);
                sent += POOL_SIZE;
            end else if (pick < 88) begin
                p = $urandom_range(0, POOL_SIZE - 1);
                send_beat(MODE_CLASSIFY, pool_pix[p], near_value(pool_base[p][0], 40),
                          near_value(pool_base[p][1], 40), near_value(pool_base[p][2], 40),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_beat(1'($urandom_range(0, 1)), PIX_IDX_W'($urandom_range(0, 65535)),
                          SAMPLE_W'($urandom_range(0, 255)), SAMPLE_W'($urandom_range(0, 255)),
                          SAMPLE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed beats, then a series of settings.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_THRESHOLD;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_mode        <= MODE_LEARN;
        i_pixel_index <= '0;
        i_blue        <= '0;
        i_green       <= '0;
        i_red         <= '0;
        i_frame_end   <= 1'b0;
        sb            = new();
        burst_left    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: unwritten history reads as zero, threshold edge at 20.
        send_beat(MODE_CLASSIFY, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_beat(MODE_CLASSIFY, 16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b0);
        send_beat(MODE_CLASSIFY, 16'h1234, 8'd19, 8'd20, 8'd21, 1'b0);
        send_beat(MODE_LEARN, 16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b0);
        send_beat(MODE_CLASSIFY, 16'hFFFF, 8'd255, 8'd236, 8'd235, 1'b0);
        send_beat(MODE_LEARN, 16'd0, 8'hAA, 8'h55, 8'h80, 1'b1);
        send_beat(MODE_LEARN, 16'd0, 8'h55, 8'hAA, 8'h7F, 1'b1);
        send_beat(MODE_CLASSIFY, 16'd0, 8'hAA, 8'hAA, 8'h80, 1'b0);
        // Frame end on a classify beat must not move the slot.
        send_beat(MODE_CLASSIFY, 16'd0, 8'h40, 8'h40, 8'h40, 1'b1);
        // Run the slot through the rest of the ring until it wraps to slot 0.
        for (int i = 0; i < 6; i++)
            send_beat(MODE_LEARN, 16'd100, 8'(10 * i), 8'(100 + i), 8'(200 + i), 1'b1);
        send_beat(MODE_CLASSIFY, 16'd100, 8'd30, 8'd103, 8'd255, 1'b0);
        send_beat(MODE_LEARN, 16'd100, 8'hFF, 8'h00, 8'h01, 1'b0);
        send_beat(MODE_CLASSIFY, 16'd100, 8'h00, 8'hFF, 8'h7E, 1'b0);

        apply_setting(9'd0, 2'd3, 4'd8);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd256, 2'd3, 4'd8);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd1, 2'd1, 4'd1);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd20, 2'd2, 4'd3);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd30, 2'd0, 4'd8);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd15, 2'd3, 4'd15);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd25, 2'd3, 4'd0);
        run_phase(PHASE_ITEMS);
        apply_setting(9'd12, 2'd3, 4'd5);
        run_phase(PHASE_ITEMS);
        for (int i = 0; i < 3; i++) begin
            apply_setting(THR_W'($urandom_range(0, 256)), NCH_W'($urandom_range(0, 3)),
                          NHIST_W'($urandom_range(0, 15)));
            run_phase(PHASE_ITEMS);
        end

        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Output side: stall styles that change at random, plus one long hold-off.
    initial begin
        int unsigned style;
        int unsigned span;
        i_ready  <= 1'b0;
        held_off = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 80);
            repeat (span) begin
                @(posedge i_clk);
                if (!held_off && mask_beats >= 60) begin
                    held_off = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (style)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= ($urandom_range(0, 1) == 0);
                    2:       i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ~i_ready;
                endcase
            end
        end
    end

    // Check each mask beat taken at a clock edge.
    initial mask_beats = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            mask_beats++;
            sb.check_beat('{o_pixel_out, o_fg_blue, o_fg_green, o_fg_red});
        end
    end

    // Watchdog.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
